[src/heater_pid_multichannel_defines.svh]
// Assertion helpers for the heater PID block.
`ifndef HEATER_PID_MULTICHANNEL_DEFINES_SVH
`define HEATER_PID_MULTICHANNEL_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define HPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked in the same cycle as the antecedent
`define HPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[src/hpm_pkg.sv]
`default_nettype none

package hpm_pkg;

  localparam int CHANNELS_DEF = 4;

  localparam int CH_PORT_W  = 2;
  localparam int TEMP_W     = 16;
  localparam int GAIN_W     = 26;
  localparam int SMOOTH_W   = 17;
  localparam int LIMIT_W    = 31;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN       = 3'd0,
    CFG_INTEG_GAIN      = 3'd1,
    CFG_DERIV_GAIN      = 3'd2,
    CFG_DERIV_SMOOTHING = 3'd3,
    CFG_INTEGRAL_LIMIT  = 3'd4,
    CFG_OUTPUT_MAX      = 3'd5
  } cfg_idx_t;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST       = 26'd408848;
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST      = 26'd25553;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST      = 26'd6541604;
  localparam logic [SMOOTH_W-1:0] DERIV_SMOOTHING_RST = 17'd62259;
  localparam logic [LIMIT_W-1:0]  INTEGRAL_LIMIT_RST  = 31'd10464;
  localparam logic [DRIVE_W-1:0]  OUTPUT_MAX_RST      = 16'd65280;

  // smoothing weight of one, Q1.16
  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE = 17'd65536;

endpackage

`default_nettype wire

[src/hpm_serial_mul.sv]
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle, LSB first.
// A signed multiplier has its top bit weighted negative (subtract on last step).
module hpm_serial_mul #(
  parameter int   A_W      = 27,
  parameter int   B_W      = 16,
  parameter bit   B_SIGNED = 1'b1,
  parameter int   P_W      = A_W + B_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic signed [A_W-1:0] a,
  input  wire logic        [B_W-1:0] b,
  output logic                       busy,
  output logic signed [P_W-1:0]      product
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic signed [P_W-1:0] a_sh;
  logic [B_W-1:0]        b_sh;
  logic [CNT_W-1:0]      cnt;
  logic                  last;

  assign last = (cnt == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(B_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh    <= P_W'(a);
      b_sh    <= b;
      product <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        if (last && B_SIGNED) begin
          product <= product - a_sh;
        end else begin
          product <= product + a_sh;
        end
      end
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

`default_nettype wire

[src/heater_pid_multichannel.sv]
`default_nettype none

// Multichannel heater PID controller. A request on the input channel is either
// a sample (req_type 0: channel, measured temperature and error, both signed
// Q12.4) or a restart (req_type 1: arms or disarms the channel's restart flag,
// no result). Each sample in range yields one result: out_channel and drive,
// unsigned Q8.8 clamped to 0..output_max, computed as P + I - D with an
// integral clamped to 0..integral_limit and a derivative on measurement
// passed through a first-order smoother. An armed channel clears its
// integral and reuses the sample's measurement as the previous one.
// Requests naming a channel at or above CHANNELS are dropped.
// Sequence: a sample holds in_ready low from when it is taken until its result
// is loaded into the output register, so no new sample is taken while one is
// in flight. The time is set by the serial integral multiply (31 bits of
// accumulated error, one bit per cycle, then a step to see it done) followed
// by the 17-bit serial smoother multiplies, with six steps around them. A
// result still waiting for out_ready stretches the last step. Restart and
// dropped requests leave the block idle. The finished drive sits in an output
// register, so the next request is taken while that result waits for out_ready.
// Gains and limits are written through the cfg port (index = register order:
// prop_gain, integ_gain, deriv_gain, deriv_smoothing, integral_limit,
// output_max); the user must write them only while the block is idle, which
// the block itself does not enforce; cfg_ready is always high.
module heater_pid_multichannel #(
  parameter int CHANNELS = hpm_pkg::CHANNELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // request channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                req_type,
  input  wire logic [hpm_pkg::CH_PORT_W-1:0]       channel,
  input  wire logic                                restart_value,
  input  wire logic signed [hpm_pkg::TEMP_W-1:0]   measured,
  input  wire logic signed [hpm_pkg::TEMP_W-1:0]   error,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [hpm_pkg::CH_PORT_W-1:0]            out_channel,
  output logic [hpm_pkg::DRIVE_W-1:0]              drive,
  // configuration write channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [hpm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [hpm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import hpm_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // product widths; gains enter as 27-bit signed (zero top bit)
  localparam int GA_W   = GAIN_W + 1;
  localparam int DIFF_W = TEMP_W + 1;
  localparam int DF_W   = 32;
  localparam int PP_W   = GA_W + TEMP_W;     // P, Q.20
  localparam int IP_W   = GA_W + LIMIT_W;    // I, Q.20
  localparam int RP_W   = GA_W + DIFF_W;     // raw derivative, Q.20
  localparam int SP_W   = RP_W + SMOOTH_W;   // raw * (1 - k), Q.36
  localparam int FP_W   = DF_W + SMOOTH_W;   // old filtered * k, Q.24
  localparam int T_W    = SP_W + 2;          // smoother sum
  localparam int DN_W   = T_W - 28;          // smoother result before saturation
  localparam int SUM_W  = IP_W + 2;          // P + I - D sum
  localparam int DRV_W  = SUM_W - 12;        // drive before clamp

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_LOAD   = 9'b000000010,
    ST_PREP   = 9'b000000100,
    ST_START1 = 9'b000001000,
    ST_MUL1   = 9'b000010000,
    ST_START2 = 9'b000100000,
    ST_MUL2   = 9'b001000000,
    ST_FIN1   = 9'b010000000,
    ST_FIN2   = 9'b100000000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [GAIN_W-1:0]   prop_gain, integ_gain, deriv_gain;
  logic [SMOOTH_W-1:0] deriv_smoothing;
  logic [LIMIT_W-1:0]  integral_limit;
  logic [DRIVE_W-1:0]  output_max;

  // per-channel state
  logic [LIMIT_W-1:0]       integ_mem [CHANNELS];
  logic signed [TEMP_W-1:0] prev_mem  [CHANNELS];
  logic signed [DF_W-1:0]   df_mem    [CHANNELS];
  logic                     flag_mem  [CHANNELS];

  // working registers for the request in flight
  logic [CH_PORT_W-1:0]     ch_r;
  logic [CH_W-1:0]          idx_r;
  logic signed [TEMP_W-1:0] meas_r, err_r;
  logic [LIMIT_W-1:0]       integ_rd;
  logic signed [TEMP_W-1:0] prev_rd;
  logic signed [DF_W-1:0]   df_rd;
  logic                     flag_rd;
  logic [LIMIT_W-1:0]       acc_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [DF_W-1:0]   dnew_r;

  logic in_acc, in_range, out_free;
  logic [CH_W-1:0] in_idx;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_range  = (32'(channel) < 32'(CHANNELS));
  assign in_idx    = CH_W'(channel);
  assign out_free  = !out_valid || out_ready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= PROP_GAIN_RST;
      integ_gain      <= INTEG_GAIN_RST;
      deriv_gain      <= DERIV_GAIN_RST;
      deriv_smoothing <= DERIV_SMOOTHING_RST;
      integral_limit  <= INTEGRAL_LIMIT_RST;
      output_max      <= OUTPUT_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PROP_GAIN:       prop_gain       <= cfg_data[GAIN_W-1:0];
        CFG_INTEG_GAIN:      integ_gain      <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_GAIN:      deriv_gain      <= cfg_data[GAIN_W-1:0];
        CFG_DERIV_SMOOTHING: deriv_smoothing <= cfg_data[SMOOTH_W-1:0];
        CFG_INTEGRAL_LIMIT:  integral_limit  <= cfg_data[LIMIT_W-1:0];
        CFG_OUTPUT_MAX:      output_max      <= cfg_data[DRIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  logic p_busy, i_busy, r_busy, s_busy, f_busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc && in_range && req_type == REQ_SAMPLE) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD:   state_next = ST_PREP;
      ST_PREP:   state_next = ST_START1;
      ST_START1: state_next = ST_MUL1;
      ST_MUL1: begin
        if (!p_busy && !i_busy && !r_busy) begin
          state_next = ST_START2;
        end
      end
      ST_START2: state_next = ST_MUL2;
      ST_MUL2: begin
        if (!s_busy && !f_busy) begin
          state_next = ST_FIN1;
        end
      end
      ST_FIN1:   state_next = ST_FIN2;
      ST_FIN2: begin
        // hold here until the output register can take the result
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------- integral update and measurement delta ----------------
  logic [LIMIT_W-1:0]        integ_base;
  logic signed [TEMP_W-1:0]  prev_base;
  logic signed [LIMIT_W+1:0] integ_sum;
  logic [LIMIT_W-1:0]        acc_next;
  logic signed [DIFF_W-1:0]  diff_next;

  always_comb begin
    // armed channel: integral restarts from zero, delta is zero
    integ_base = flag_rd ? '0 : integ_rd;
    prev_base  = flag_rd ? meas_r : prev_rd;
    integ_sum  = signed'({2'b00, integ_base}) + (LIMIT_W+2)'(err_r);
    if (integ_sum < 0) begin
      acc_next = '0;
    end else if (integ_sum > signed'({2'b00, integral_limit})) begin
      acc_next = integral_limit;
    end else begin
      acc_next = integ_sum[LIMIT_W-1:0];
    end
    diff_next = DIFF_W'(meas_r) - DIFF_W'(prev_base);
  end

  // ---------------- serial multipliers ----------------
  logic start1, start2;
  logic signed [PP_W-1:0] p_prod;
  logic signed [IP_W-1:0] i_prod;
  logic signed [RP_W-1:0] r_prod;
  logic signed [SP_W-1:0] s_prod;
  logic signed [FP_W-1:0] f_prod;
  logic [SMOOTH_W-1:0]    k_sat, k_rest;

  assign start1 = (state == ST_START1);
  assign start2 = (state == ST_START2);
  // weights above one count as one
  assign k_sat  = (deriv_smoothing > SMOOTH_ONE) ? SMOOTH_ONE : deriv_smoothing;
  assign k_rest = SMOOTH_ONE - k_sat;

  hpm_serial_mul #(.A_W(GA_W), .B_W(TEMP_W), .B_SIGNED(1'b1), .P_W(PP_W)) u_mul_p (
    .clk(clk), .rst(rst), .start(start1),
    .a(signed'({1'b0, prop_gain})), .b(err_r),
    .busy(p_busy), .product(p_prod)
  );

  hpm_serial_mul #(.A_W(GA_W), .B_W(LIMIT_W), .B_SIGNED(1'b0), .P_W(IP_W)) u_mul_i (
    .clk(clk), .rst(rst), .start(start1),
    .a(signed'({1'b0, integ_gain})), .b(acc_r),
    .busy(i_busy), .product(i_prod)
  );

  hpm_serial_mul #(.A_W(GA_W), .B_W(DIFF_W), .B_SIGNED(1'b1), .P_W(RP_W)) u_mul_r (
    .clk(clk), .rst(rst), .start(start1),
    .a(signed'({1'b0, deriv_gain})), .b(diff_r),
    .busy(r_busy), .product(r_prod)
  );

  hpm_serial_mul #(.A_W(RP_W), .B_W(SMOOTH_W), .B_SIGNED(1'b0), .P_W(SP_W)) u_mul_s (
    .clk(clk), .rst(rst), .start(start2),
    .a(r_prod), .b(k_rest),
    .busy(s_busy), .product(s_prod)
  );

  hpm_serial_mul #(.A_W(DF_W), .B_W(SMOOTH_W), .B_SIGNED(1'b0), .P_W(FP_W)) u_mul_f (
    .clk(clk), .rst(rst), .start(start2),
    .a(df_rd), .b(k_sat),
    .busy(f_busy), .product(f_prod)
  );

  // ---------------- smoother: round half up at Q.36 -> Q.8, saturate ----------------
  logic signed [T_W-1:0]  t_sum;
  logic signed [DN_W-1:0] dn_full;
  logic signed [DF_W-1:0] dnew_sat;

  always_comb begin
    t_sum   = T_W'(s_prod) + (T_W'(f_prod) <<< 12) + (T_W'(1) <<< 27);
    dn_full = t_sum[T_W-1:28];
    if (dn_full > DN_W'(32'sh7fffffff)) begin
      dnew_sat = 32'sh7fffffff;
    end else if (dn_full < -(DN_W'(33'sh080000000))) begin
      dnew_sat = 32'sh80000000;
    end else begin
      dnew_sat = dn_full[DF_W-1:0];
    end
  end

  // ---------------- drive: P + I - D, round to Q8.8, clamp ----------------
  logic signed [SUM_W-1:0] pid_sum;
  logic signed [DRV_W-1:0] drv_full;
  logic [DRIVE_W-1:0]      drv_clamp;

  always_comb begin
    pid_sum  = SUM_W'(p_prod) + SUM_W'(i_prod) - (SUM_W'(dnew_r) <<< 12)
               + SUM_W'(2048);
    drv_full = pid_sum[SUM_W-1:12];
    if (drv_full < 0) begin
      drv_clamp = '0;
    end else if (drv_full > signed'(DRV_W'(output_max))) begin
      drv_clamp = output_max;
    end else begin
      drv_clamp = drv_full[DRIVE_W-1:0];
    end
  end

  // ---------------- working registers ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r   <= channel;
      idx_r  <= in_idx;
      meas_r <= measured;
      err_r  <= error;
    end
    if (state == ST_LOAD) begin
      integ_rd <= integ_mem[idx_r];
      prev_rd  <= prev_mem[idx_r];
      df_rd    <= df_mem[idx_r];
      flag_rd  <= flag_mem[idx_r];
    end
    if (state == ST_PREP) begin
      acc_r  <= acc_next;
      diff_r <= diff_next;
    end
    if (state == ST_FIN1) begin
      dnew_r <= dnew_sat;
    end
  end

  // ---------------- channel state ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integ_mem[i] <= '0;
        prev_mem[i]  <= '0;
        df_mem[i]    <= '0;
        flag_mem[i]  <= 1'b0;
      end
    end else begin
      if (in_acc && in_range && req_type == REQ_RESTART) begin
        flag_mem[in_idx] <= restart_value;
      end
      if (state == ST_LOAD) begin
        flag_mem[idx_r] <= 1'b0;   // restart is consumed by this sample
      end
      if (state == ST_FIN1) begin
        integ_mem[idx_r] <= acc_r;
        prev_mem[idx_r]  <= meas_r;
        df_mem[idx_r]    <= dnew_sat;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN2 && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN2 && out_free) begin
      out_channel <= ch_r;
      drive       <= drv_clamp;
    end
  end

endmodule

`default_nettype wire

[src/hpm_checker.sv]
`default_nettype none

`include "heater_pid_multichannel_defines.svh"

module hpm_checker #(
  parameter int CHANNELS = hpm_pkg::CHANNELS_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          req_type,
  input wire logic [hpm_pkg::CH_PORT_W-1:0] channel,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [hpm_pkg::CH_PORT_W-1:0] out_channel,
  input wire logic [hpm_pkg::DRIVE_W-1:0]   drive
);

  import hpm_pkg::*;

  logic sample_req;

  assign sample_req = in_valid && in_ready && req_type == REQ_SAMPLE
                      && (32'(channel) < 32'(CHANNELS));

  // a stalled result holds
  `HPM_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(drive) && $stable(out_channel), "result changed while stalled")

  // an accepted sample occupies the datapath
  `HPM_ASSERT_NEXT(a_busy_after_sample, clk, rst, sample_req, !in_ready, "request taken while a sample is in flight")

  // a new result only appears at the end of a sample's computation
  `HPM_ASSERT_NOW(a_result_after_work, clk, rst, $rose(out_valid), $past(!in_ready), "result appeared without a sample in flight")

endmodule

bind heater_pid_multichannel hpm_checker #(.CHANNELS(CHANNELS)) u_hpm_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .channel(channel),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_channel(out_channel), .drive(drive)
);

`default_nettype wire
